// ===== rtl/core/dfspf_pkg.sv =====
// Package for the depth-first path finder: sizes, microcode encodings and
// the control store holding the search program.
// No dependencies; imported by dfs_path_finder and its checker.
package dfspf_pkg;

   // Sizes of the room space and of the fields that carry room numbers.
   localparam int ROOMS    = 16;
   localparam int ROOM_W   = 4;
   localparam int DEPTH_W  = $clog2(ROOMS + 1);
   localparam int ROW_W    = ROOMS;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;
   localparam int COUNT_W  = 5;
   localparam logic [COUNT_W-1:0] ROOM_COUNT_RESET = COUNT_W'(16);

   // Configuration register indexes.
   localparam logic REG_ROOM_COUNT = 1'b0;
   localparam logic REG_START_ROOM = 1'b1;

   // Input item function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   // Addresses of the steps in the control store.
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type ST_IDLE   = 3'd0;
   localparam step_type ST_INIT   = 3'd1;
   localparam step_type ST_EMPTY  = 3'd2;
   localparam step_type ST_ATDEST = 3'd3;
   localparam step_type ST_SCAN   = 3'd4;
   localparam step_type ST_EMIT   = 3'd5;
   localparam step_type ST_FAIL   = 3'd6;

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_INIT,
      OP_NONE,
      OP_SCAN,
      OP_EMIT,
      OP_FAIL
   } op_type;

   // Branch condition tested by a control word.
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_FIND,
      C_RANGE_BAD,
      C_EMPTY,
      C_AT_DEST,
      C_LAST
   } cond_type;

   // One control word: operation, condition and the two branch targets.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_type;

   // The search program. Each scan step pushes one neighbour or pops one room.
   function automatic ctrl_type ctrl_rom(input step_type step);
      ctrl_type cw;
      case (step)
         ST_IDLE:   cw = '{OP_IDLE, C_FIND,      ST_INIT,  ST_IDLE};
         ST_INIT:   cw = '{OP_INIT, C_RANGE_BAD, ST_FAIL,  ST_EMPTY};
         ST_EMPTY:  cw = '{OP_NONE, C_EMPTY,     ST_FAIL,  ST_ATDEST};
         ST_ATDEST: cw = '{OP_NONE, C_AT_DEST,   ST_EMIT,  ST_SCAN};
         ST_SCAN:   cw = '{OP_SCAN, C_ALWAYS,    ST_EMPTY, ST_EMPTY};
         ST_EMIT:   cw = '{OP_EMIT, C_LAST,      ST_IDLE,  ST_EMIT};
         ST_FAIL:   cw = '{OP_FAIL, C_ALWAYS,    ST_IDLE,  ST_IDLE};
         default:   cw = '{OP_NONE, C_ALWAYS,    ST_IDLE,  ST_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/core/dfs_path_finder.sv =====
// Top level of the depth-first path finder: APB register port, microcoded
// sequencer, adjacency store, search stack and result register.
// Depends on dfspf_pkg.
//
// An input transaction is taken at a rising edge with start high and busy
// low. A load (req_func at load) writes req_row_bits to adjacency row
// req_row_index at once and busy stays low. A find runs a depth-first search
// from start_room to req_destination over the first room_count rooms.
// Results leave one per cycle on rsp_room, rsp_found and rsp_last, each
// marked by rsp_valid for one cycle; the receiver cannot stall them. A found
// path comes out start room first with rsp_last on the destination, else the
// start room alone with rsp_found low.
// Sequence: a set-up step, then for each stack push or pop the three steps
// test empty, test destination and row scan. busy stays high through them
// and through the emit steps that send a found path, or the fail step when
// unreachable; an endpoint outside the rooms in use goes from set-up straight
// to the fail step. busy drops in the cycle that shows the final result,
// so the next transaction can be taken there.
// Reset (synchronous, active high) idles the sequencer and sets room_count to
// 16 and start_room to 0; adjacency rows are undefined until loaded.
module dfs_path_finder (
   input  logic                           clock,
   input  logic                           reset,
   // Input channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [dfspf_pkg::ROOM_W-1:0]   req_row_index,
   input  logic [dfspf_pkg::ROW_W-1:0]    req_row_bits,
   input  logic [dfspf_pkg::ROOM_W-1:0]   req_destination,
   // Result channel
   output logic                           rsp_valid,
   output logic [dfspf_pkg::ROOM_W-1:0]   rsp_room,
   output logic                           rsp_found,
   output logic                           rsp_last,
   // Configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dfspf_pkg::PADDR_W-1:0]  paddr,
   input  logic [dfspf_pkg::CSR_W-1:0]    pwdata,
   output logic [dfspf_pkg::CSR_W-1:0]    prdata,
   output logic                           pready
);
   import dfspf_pkg::*;

   // Registers
   logic [COUNT_W-1:0]  room_count_ff;
   logic [ROOM_W-1:0]   start_room_ff;
   step_type            step_ff, step_in;
   logic [ROOM_W-1:0]   dest_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [DEPTH_W-1:0]  emit_ff;
   logic [ROW_W-1:0]    visited_ff;
   logic                rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [ROOM_W-1:0]   rsp_room_ff;
   logic [ROW_W-1:0]    adj_ff      [ROOMS];
   logic [ROOM_W-1:0]   stack_ff    [ROOMS];
   logic [DEPTH_W-1:0]  next_try_ff [ROOMS];

   // Combinational signals
   ctrl_type            cw;
   logic                cond_true;
   logic                csr_write;
   logic                take;
   logic [DEPTH_W-1:0]  rooms_used;
   logic                range_bad;
   logic [ROOM_W-1:0]   rd_addr;
   logic [ROOM_W-1:0]   top_room;
   logic [DEPTH_W-1:0]  top_next;
   logic [ROW_W-1:0]    top_row;
   logic [ROW_W-1:0]    cand;
   logic [ROW_W-1:0]    cand_low;
   logic [ROOM_W-1:0]   cand_idx;
   logic                emit_last;

   // Register port: writes complete in the access phase, reads are direct.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      if (paddr[2] == REG_START_ROOM) begin
         prdata = CSR_W'(start_room_ff);
      end else begin
         prdata = CSR_W'(room_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= ROOM_COUNT_RESET;
         start_room_ff <= '0;
      end else if (csr_write) begin
         if (paddr[2] == REG_START_ROOM) begin
            start_room_ff <= pwdata[ROOM_W-1:0];
         end else begin
            room_count_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   // Rooms in use: room_count clamped to the range one to ROOMS.
   always_comb begin
      if (room_count_ff == '0) begin
         rooms_used = DEPTH_W'(1);
      end else if (COUNT_W'(room_count_ff) > COUNT_W'(ROOMS)) begin
         rooms_used = DEPTH_W'(ROOMS);
      end else begin
         rooms_used = DEPTH_W'(room_count_ff);
      end
   end

   assign range_bad = (DEPTH_W'(start_room_ff) >= rooms_used)
                    | (DEPTH_W'(dest_ff) >= rooms_used);

   // Control store fetch and input handshake.
   assign cw   = ctrl_rom(step_ff);
   assign busy = (cw.op != OP_IDLE);
   assign take = start & ~busy;

   // The stack has a single read address: the top while searching, the
   // emit pointer while the path goes out.
   assign rd_addr  = (cw.op == OP_EMIT) ? emit_ff[ROOM_W-1:0]
                                        : ROOM_W'(depth_ff - DEPTH_W'(1));
   assign top_room = stack_ff[rd_addr];
   assign top_next = next_try_ff[rd_addr];
   assign top_row  = adj_ff[top_room];
   assign emit_last = (emit_ff + DEPTH_W'(1)) == depth_ff;

   // Neighbour candidates of the top room, from its resume point upwards.
   always_comb begin
      for (int j = 0; j < ROOMS; j++) begin
         cand[j] = top_row[j] & ~visited_ff[j]
                 & (ROOM_W'(j) != top_room)
                 & (DEPTH_W'(j) >= top_next)
                 & (DEPTH_W'(j) < rooms_used);
      end
   end

   // Lowest candidate: isolate the lowest set bit, then encode it.
   assign cand_low = cand & (~cand + ROW_W'(1));

   always_comb begin
      cand_idx = '0;
      for (int j = 0; j < ROOMS; j++) begin
         if (cand_low[j]) begin
            cand_idx = cand_idx | ROOM_W'(j);
         end
      end
   end

   // Branch condition of the current control word.
   always_comb begin
      case (cw.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_FIND:      cond_true = take & (req_func == FUNC_FIND);
         C_RANGE_BAD: cond_true = range_bad;
         C_EMPTY:     cond_true = (depth_ff == '0);
         C_AT_DEST:   cond_true = (top_room == dest_ff);
         C_LAST:      cond_true = emit_last;
         default:     cond_true = 1'b0;
      endcase
   end

   assign step_in = cond_true ? cw.on_true : cw.on_false;

   // Sequencer step counter and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= (cw.op == OP_EMIT) | (cw.op == OP_FAIL);
      end
      case (cw.op)
         OP_EMIT: begin
            rsp_room_ff  <= top_room;
            rsp_found_ff <= 1'b1;
            rsp_last_ff  <= emit_last;
         end
         default: begin
            rsp_room_ff  <= start_room_ff;
            rsp_found_ff <= 1'b0;
            rsp_last_ff  <= 1'b1;
         end
      endcase
   end

   // Search datapath: adjacency loads, stack pushes and pops, visited marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         visited_ff <= '0;
         emit_ff    <= '0;
      end else begin
         case (cw.op)
            OP_IDLE: begin
               if (take) begin
                  dest_ff <= req_destination;
                  if (req_func == FUNC_LOAD) begin
                     adj_ff[req_row_index] <= req_row_bits;
                  end
               end
            end
            OP_INIT: begin
               emit_ff <= '0;
               if (!range_bad) begin
                  stack_ff[0]    <= start_room_ff;
                  next_try_ff[0] <= '0;
                  depth_ff       <= DEPTH_W'(1);
                  visited_ff     <= ROW_W'(1) << start_room_ff;
               end else begin
                  depth_ff   <= '0;
                  visited_ff <= '0;
               end
            end
            OP_SCAN: begin
               if (cand != '0) begin
                  next_try_ff[rd_addr] <= DEPTH_W'(cand_idx) + DEPTH_W'(1);
                  visited_ff           <= visited_ff | cand_low;
                  if (depth_ff < rooms_used) begin
                     stack_ff[depth_ff[ROOM_W-1:0]]    <= cand_idx;
                     next_try_ff[depth_ff[ROOM_W-1:0]] <= '0;
                     depth_ff                          <= depth_ff + DEPTH_W'(1);
                  end
               end else begin
                  depth_ff <= depth_ff - DEPTH_W'(1);
               end
            end
            OP_EMIT: begin
               emit_ff <= emit_ff + DEPTH_W'(1);
            end
            OP_FAIL: begin
               depth_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_room  = rsp_room_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== rtl/core/dfspf_checker.sv =====
// Port-level checker for the depth-first path finder, with its bind.
// Depends on dfspf_pkg and attaches to dfs_path_finder.
module dfspf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_func,
   input logic                           rsp_valid,
   input logic                           rsp_found,
   input logic                           rsp_last
);
   import dfspf_pkg::*;

   // A run of rooms goes out without gaps until its final transaction.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("result run broken before its final room");

   // Only a found path is longer than one room.
   a_long_run_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("failed search emitted more than one room");

   // The block is free again as the final room of a run is shown.
   a_idle_at_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy still high at the final result");

   // A find transaction occupies the block from the next cycle.
   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == FUNC_FIND) |=> busy && !rsp_valid)
      else $error("find transaction did not start a search");

endmodule

bind dfs_path_finder dfspf_checker u_dfspf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_func  (req_func),
   .rsp_valid (rsp_valid),
   .rsp_found (rsp_found),
   .rsp_last  (rsp_last)
);
